// File: rtl/pbb_pkg.sv
`default_nettype none
package pbb_pkg;

    localparam int LINE_LEN  = 256;
    localparam int NUM_LINES = 3;
    localparam int PAL_DEPTH = 256;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [7:0] WIDTH_RST  = 8'd16;
    localparam logic [7:0] HEIGHT_RST = 8'd16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       nb_clr;
        logic       line_rd;
        logic       pal_nb;
        logic       acc;
        logic       div_init;
        logic       div_step;
        logic       srch_init;
        logic       srch_rd;
        logic       srch_cmp;
        logic [7:0] srch_addr;
        logic [7:0] cmp_idx;
        logic       put;
        logic       next_res;
        logic [1:0] ny;
        logic [1:0] nx;
    } t_cmd;

    typedef struct packed {
        logic has_work;
        logic last_res;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/palette_box_blur_3x3.sv
// A pixel beat releases up to four results; each result passes through the nine
// neighbor reads, the division, the palette scan and the output step, in that order.
// A new input beat is taken only once every result of the last one is out; palette
// loads start no result work. The single palette memory read port is scanned one entry per cycle.
// Reset (synchronous, active low) clears control state and all palette valid bits
// at once, so the palette reads as zero right away; no clearing pass is needed.
`default_nettype none
module palette_box_blur_3x3 (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_op,
    input  wire  [7:0]  i_pixel_index,
    input  wire  [7:0]  i_palette_slot,
    input  wire  [15:0] i_palette_color,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_index,
    output logic [7:0]  o_out_col,
    output logic [7:0]  o_out_row,
    output logic        o_last,
    output logic        o_frame_end,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [7:0]  i_cfg_data
);

    // The controller walks each result through neighbor gathering, division
    // and the palette scan; the datapath holds memories, counters and the
    // output register.
    pbb_pkg::t_cmd cmd;
    pbb_pkg::t_sts sts;

    pbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pbb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_op),
        .i_pixel_index   (i_pixel_index),
        .i_palette_slot  (i_palette_slot),
        .i_palette_color (i_palette_color),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_index     (o_out_index),
        .o_out_col       (o_out_col),
        .o_out_row       (o_out_row),
        .o_last          (o_last),
        .o_frame_end     (o_frame_end)
    );

    // The result beat for the last pixel of a frame is always the final one
    // caused by its input beat.
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_last)
        else $error("frame end without last");

    // A palette load never starts result work.
    a_load_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == pbb_pkg::OP_LOAD) |=> o_in_ready)
        else $error("palette load blocked the input");

    // No result beat is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// File: rtl/pbb_ctrl.sv
`default_nettype none
module pbb_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  pbb_pkg::t_sts     i_sts,
    output logic              o_in_ready,
    output pbb_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LINE = 3'd1;
    localparam logic [2:0] S_PAL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SRCH = 3'd5;
    localparam logic [2:0] S_PUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [8:0] r_cnt, n_cnt;
    logic [1:0] r_ny, n_ny, r_nx, n_nx;
    logic [8:0] cnt_m1;

    assign cnt_m1 = r_cnt - 9'd1;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ny       = r_ny;
        n_nx       = r_nx;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.ny   = r_ny;
        o_cmd.nx   = r_nx;
        o_cmd.srch_addr = r_cnt[7:0];
        o_cmd.cmp_idx   = cnt_m1[7:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.has_work) begin
                        o_cmd.nb_clr = 1'b1;
                        n_ny    = 2'd0;
                        n_nx    = 2'd0;
                        n_state = S_LINE;
                    end
                end
            end
            S_LINE: begin
                o_cmd.line_rd = 1'b1;
                n_state = S_PAL;
            end
            S_PAL: begin
                o_cmd.pal_nb = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_LINE;
                if (r_nx == 2'd2) begin
                    n_nx = 2'd0;
                    if (r_ny == 2'd2) begin
                        n_cnt   = 9'd0;
                        n_state = S_DIV;
                    end else begin
                        n_ny = r_ny + 2'd1;
                    end
                end else begin
                    n_nx = r_nx + 2'd1;
                end
            end
            S_DIV: begin
                if (r_cnt == 9'd0) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_cnt == 9'd9) begin
                    o_cmd.srch_init = 1'b1;
                    n_cnt   = 9'd0;
                    n_state = S_SRCH;
                end else begin
                    n_cnt = r_cnt + 9'd1;
                end
            end
            S_SRCH: begin
                o_cmd.srch_rd  = ~r_cnt[8];
                o_cmd.srch_cmp = (r_cnt != 9'd0);
                if (r_cnt[8]) begin
                    n_state = S_PUT;
                end else begin
                    n_cnt = r_cnt + 9'd1;
                end
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    if (i_sts.last_res) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_res = 1'b1;
                        o_cmd.nb_clr   = 1'b1;
                        n_ny    = 2'd0;
                        n_nx    = 2'd0;
                        n_state = S_LINE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ny    <= '0;
            r_nx    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ny    <= n_ny;
            r_nx    <= n_nx;
        end
    end

endmodule
`default_nettype wire

// File: rtl/pbb_dp.sv
`default_nettype none
module pbb_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  pbb_pkg::t_cmd     i_cmd,
    output pbb_pkg::t_sts     o_sts,
    input  wire               i_op,
    input  wire  [7:0]        i_pixel_index,
    input  wire  [7:0]        i_palette_slot,
    input  wire  [15:0]       i_palette_color,
    input  wire               i_cfg_we,
    input  wire               i_cfg_idx,
    input  wire  [7:0]        i_cfg_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [7:0]        o_out_index,
    output logic [7:0]        o_out_col,
    output logic [7:0]        o_out_row,
    output logic              o_last,
    output logic              o_frame_end
);

    // Configuration and frame position.
    logic [7:0] r_fw, r_fh, r_cx, r_cy;
    logic [1:0] r_cb;
    logic [7:0] ew, eh;
    logic       at_origin;

    assign ew = (r_fw == 8'd0) ? 8'd1 : r_fw;
    assign eh = (r_fh == 8'd0) ? 8'd1 : r_fh;
    assign at_origin = (r_cx == 8'd0) && (r_cy == 8'd0);

    // Release window of the accepted pixel.
    logic has_rows, has_cols, cx_end, cy_end;
    logic [7:0] xs, xe, ys, ye;

    assign cx_end   = (r_cx == ew - 8'd1);
    assign cy_end   = (r_cy == eh - 8'd1);
    assign has_rows = (r_cy != 8'd0) || cy_end;
    assign has_cols = (r_cx != 8'd0) || cx_end;
    assign xs = (r_cx != 8'd0) ? r_cx - 8'd1 : r_cx;
    assign xe = cx_end ? r_cx : r_cx - 8'd1;
    assign ys = (r_cy != 8'd0) ? r_cy - 8'd1 : r_cy;
    assign ye = cy_end ? r_cy : r_cy - 8'd1;

    logic [7:0] r_ox, r_oy, r_xs, r_xe, r_ye, r_py, r_pw, r_ph;
    logic [1:0] r_pcb;
    logic       last_res;

    assign last_res = (r_ox == r_xe) && (r_oy == r_ye);

    logic pix_acc, load_acc;
    assign pix_acc  = i_cmd.accept && (i_op == pbb_pkg::OP_PIXEL);
    assign load_acc = i_cmd.accept && (i_op == pbb_pkg::OP_LOAD) && at_origin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= pbb_pkg::WIDTH_RST;
            r_fh <= pbb_pkg::HEIGHT_RST;
            r_cx <= '0;
            r_cy <= '0;
            r_cb <= '0;
        end else begin
            if (i_cfg_we && at_origin) begin
                case (i_cfg_idx)
                    pbb_pkg::CFG_WIDTH:  r_fw <= i_cfg_data;
                    pbb_pkg::CFG_HEIGHT: r_fh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (pix_acc) begin
                if (cx_end) begin
                    r_cx <= '0;
                    r_cb <= (r_cb == 2'd2) ? 2'd0 : r_cb + 2'd1;
                    r_cy <= cy_end ? 8'd0 : r_cy + 8'd1;
                end else begin
                    r_cx <= r_cx + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_ox  <= xs;
            r_oy  <= ys;
            r_xs  <= xs;
            r_xe  <= xe;
            r_ye  <= ye;
            r_py  <= r_cy;
            r_pw  <= ew;
            r_ph  <= eh;
            r_pcb <= r_cb;
        end else if (i_cmd.next_res) begin
            if (r_ox == r_xe) begin
                r_ox <= r_xs;
                r_oy <= r_oy + 8'd1;
            end else begin
                r_ox <= r_ox + 8'd1;
            end
        end
    end

    // Line buffers: three banks of one memory, rotated at each row end.
    logic [7:0] line_mem [pbb_pkg::NUM_LINES * pbb_pkg::LINE_LEN];
    logic [9:0] rr, cc, dd;
    logic [2:0] bsum, bank;
    logic       nb_in;
    logic [9:0] line_rd_addr, line_wr_addr;
    logic [7:0] r_lq;
    logic       r_nin;

    assign rr = {2'b00, r_oy} + {8'd0, i_cmd.ny};
    assign cc = {2'b00, r_ox} + {8'd0, i_cmd.nx};
    assign nb_in = (rr != 10'd0) && (rr <= {2'b00, r_ph})
                && (cc != 10'd0) && (cc <= {2'b00, r_pw});
    // Rows above the current one sit in the banks before it.
    assign dd   = {2'b00, r_py} + 10'd1 - rr;
    assign bsum = {1'b0, r_pcb} + 3'd3 - {1'b0, dd[1:0]};
    assign bank = (bsum >= 3'd3) ? bsum - 3'd3 : bsum;
    assign line_rd_addr = {bank[1:0], 8'(cc - 10'd1)};
    assign line_wr_addr = {r_cb, r_cx};

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            line_mem[line_wr_addr] <= i_pixel_index;
        end
        if (i_cmd.line_rd) begin
            r_lq <= line_mem[line_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_rd) begin
            r_nin <= nb_in;
        end
    end

    // Palette memory with per-entry valid bits standing for the reset value.
    logic [15:0] pal_mem [pbb_pkg::PAL_DEPTH];
    logic [pbb_pkg::PAL_DEPTH-1:0] r_pv;
    logic [7:0]  pal_addr;
    logic [15:0] r_pq;
    logic        r_pvq;
    logic [15:0] col;

    assign pal_addr = i_cmd.pal_nb ? r_lq : i_cmd.srch_addr;
    assign col = r_pvq ? r_pq : 16'd0;

    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            pal_mem[i_palette_slot] <= i_palette_color;
        end
        if (i_cmd.pal_nb || i_cmd.srch_rd) begin
            r_pq <= pal_mem[pal_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= '0;
            r_pvq <= 1'b0;
        end else begin
            if (load_acc) begin
                r_pv[i_palette_slot] <= 1'b1;
            end
            if (i_cmd.pal_nb || i_cmd.srch_rd) begin
                r_pvq <= r_pv[pal_addr];
            end
        end
    end

    // Channel sums and restoring division by the neighbor count.
    logic [8:0] r_sum [3];
    logic [8:0] r_dq  [3];
    logic [3:0] r_rem [3];
    logic [3:0] r_n;
    logic [4:0] chan  [3];
    logic [3:0] nn;
    logic [4:0] rem_sh [3];
    logic       qbit  [3];
    logic [3:0] rem_nx [3];

    assign chan[0] = col[14:10];
    assign chan[1] = col[9:5];
    assign chan[2] = col[4:0];
    assign nn = (r_n == 4'd0) ? 4'd1 : r_n;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rem_sh[c] = {r_rem[c], r_dq[c][8]};
            qbit[c]   = (rem_sh[c] >= {1'b0, nn});
            rem_nx[c] = qbit[c] ? 4'(rem_sh[c] - {1'b0, nn}) : rem_sh[c][3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.nb_clr) begin
                r_sum[c] <= '0;
            end else if (i_cmd.acc && r_nin) begin
                r_sum[c] <= r_sum[c] + {4'd0, chan[c]};
            end
            if (i_cmd.div_init) begin
                r_dq[c]  <= r_sum[c];
                r_rem[c] <= '0;
            end else if (i_cmd.div_step) begin
                r_dq[c]  <= {r_dq[c][7:0], qbit[c]};
                r_rem[c] <= rem_nx[c];
            end
        end
        if (i_cmd.nb_clr) begin
            r_n <= '0;
        end else if (i_cmd.acc && r_nin) begin
            r_n <= r_n + 4'd1;
        end
    end

    // Nearest palette entry, first index wins ties.
    logic [4:0] ad [3];
    logic [6:0] nb_dist;
    logic [7:0] r_bd, r_bi;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ad[c] = (r_dq[c][4:0] > chan[c]) ? r_dq[c][4:0] - chan[c]
                                             : chan[c] - r_dq[c][4:0];
        end
        nb_dist = {2'b00, ad[0]} + {2'b00, ad[1]} + {2'b00, ad[2]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_bd <= 8'hFF;
            r_bi <= 8'd0;
        end else if (i_cmd.srch_cmp && ({1'b0, nb_dist} < r_bd)) begin
            r_bd <= {1'b0, nb_dist};
            r_bi <= i_cmd.cmp_idx;
        end
    end

    // Output register.
    logic r_ov;
    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.put) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            o_out_index <= r_bi;
            o_out_col   <= r_ox;
            o_out_row   <= r_oy;
            o_last      <= last_res;
            o_frame_end <= (r_ox == r_pw - 8'd1) && (r_oy == r_ph - 8'd1);
        end
    end

    assign o_sts.has_work = (i_op == pbb_pkg::OP_PIXEL) && has_rows && has_cols;
    assign o_sts.last_res = last_res;
    assign o_sts.out_free = ~r_ov || i_out_ready;

endmodule
`default_nettype wire
